// ===== design/mmts_pkg.sv =====
// Package with codes, test plan tables and helper functions of the march test sequencer.
package mmts_pkg;

  localparam int unsigned AddrWidth  = 16;
  localparam int unsigned DataWidth  = 8;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned RepeatAccesses = 5;
  localparam int unsigned SuiteLen   = 19;
  localparam logic [7:0]  SuiteReads = 8'd5;
  localparam logic [31:0] SuiteTicks = 32'd5000;
  localparam logic [CountWidth-1:0] CountMax = '1;

  // Operations.
  localparam logic [1:0] OP_START    = 2'd0;
  localparam logic [1:0] OP_COMPLETE = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;

  // Result kinds.
  localparam logic [1:0] RK_WRITE   = 2'd0;
  localparam logic [1:0] RK_READ    = 2'd1;
  localparam logic [1:0] RK_WAIT    = 2'd2;
  localparam logic [1:0] RK_SUMMARY = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_BASE      = 3'd0;
  localparam logic [2:0] REG_LENGTH    = 3'd1;
  localparam logic [2:0] REG_SELECT    = 3'd2;
  localparam logic [2:0] REG_PATTERN   = 3'd3;
  localparam logic [2:0] REG_PHASE     = 3'd4;
  localparam logic [2:0] REG_REPEATS   = 3'd5;
  localparam logic [2:0] REG_RETENTION = 3'd6;
  localparam logic [2:0] REG_RANDOM    = 3'd7;

  // Pass kinds.
  localparam logic [2:0] PK_W    = 3'd0;
  localparam logic [2:0] PK_WN   = 3'd1;
  localparam logic [2:0] PK_R    = 3'd2;
  localparam logic [2:0] PK_RN   = 3'd3;
  localparam logic [2:0] PK_RW   = 3'd4;
  localparam logic [2:0] PK_RD   = 3'd5;
  localparam logic [2:0] PK_WAIT = 3'd6;

  // Value codes.
  localparam logic [3:0] VC_00 = 4'd0;
  localparam logic [3:0] VC_FF = 4'd1;
  localparam logic [3:0] VC_55 = 4'd2;
  localparam logic [3:0] VC_P  = 4'd3;
  localparam logic [3:0] VC_N  = 4'd4;
  localparam logic [3:0] VC_CB = 4'd5;
  localparam logic [3:0] VC_W1 = 4'd6;
  localparam logic [3:0] VC_W0 = 4'd7;
  localparam logic [3:0] VC_X  = 4'd8;

  localparam logic [3:0] TEST_WALK1  = 4'd3;
  localparam logic [3:0] TEST_WALK0  = 4'd4;
  localparam logic [3:0] TEST_MOVINV = 4'd6;
  localparam logic [3:0] TEST_SUITE  = 4'd12;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] rv;
    logic [3:0] wv;
    logic       down;
  } pass_t;

  // One pass of a test program.
  function automatic pass_t pass_of(logic [3:0] test, logic [2:0] phase);
    pass_t p;
    p = '{kind: PK_W, rv: VC_00, wv: VC_00, down: 1'b0};
    unique case (test)
      4'd0: if (phase == 3'd0) p = '{PK_WN, VC_00, VC_55, 1'b0};
            else p = '{PK_R, VC_55, VC_00, 1'b0};
      4'd1: if (phase == 3'd0) p = '{PK_W, VC_00, VC_55, 1'b0};
            else p = '{PK_RN, VC_55, VC_00, 1'b0};
      4'd2: if (phase == 3'd0) p = '{PK_W, VC_00, VC_CB, 1'b0};
            else p = '{PK_R, VC_CB, VC_00, 1'b0};
      4'd3: if (phase == 3'd0) p = '{PK_W, VC_00, VC_W1, 1'b0};
            else p = '{PK_R, VC_W1, VC_00, 1'b0};
      4'd4: if (phase == 3'd0) p = '{PK_W, VC_00, VC_W0, 1'b0};
            else p = '{PK_R, VC_W0, VC_00, 1'b0};
      4'd5, 4'd9: begin
        unique case (phase)
          3'd0:    p = '{PK_W, VC_00, VC_00, 1'b0};
          3'd1:    p = '{PK_RW, VC_00, VC_FF, 1'b0};
          3'd2:    p = '{PK_RW, VC_FF, VC_00, 1'b1};
          default: p = '{PK_R, VC_00, VC_00, 1'b1};
        endcase
      end
      4'd6: begin
        unique case (phase)
          3'd0:    p = '{PK_W, VC_00, VC_P, 1'b0};
          3'd1:    p = '{PK_RW, VC_P, VC_N, 1'b0};
          3'd2:    p = '{PK_RW, VC_N, VC_P, 1'b0};
          default: p = '{PK_R, VC_P, VC_00, 1'b0};
        endcase
      end
      4'd7: begin
        unique case (phase)
          3'd0:    p = '{PK_W, VC_00, VC_P, 1'b0};
          3'd1:    p = '{PK_WAIT, VC_00, VC_00, 1'b0};
          default: p = '{PK_R, VC_P, VC_00, 1'b0};
        endcase
      end
      4'd8: begin
        unique case (phase)
          3'd0:    p = '{PK_W, VC_00, VC_00, 1'b0};
          3'd1:    p = '{PK_RW, VC_00, VC_FF, 1'b0};
          3'd2:    p = '{PK_RW, VC_FF, VC_00, 1'b1};
          3'd3:    p = '{PK_RW, VC_00, VC_FF, 1'b1};
          3'd4:    p = '{PK_RW, VC_FF, VC_00, 1'b0};
          default: p = '{PK_R, VC_00, VC_00, 1'b0};
        endcase
      end
      4'd10: if (phase == 3'd0) p = '{PK_W, VC_00, VC_P, 1'b0};
             else p = '{PK_RD, VC_P, VC_00, 1'b0};
      4'd11: if (phase == 3'd0) p = '{PK_W, VC_00, VC_X, 1'b0};
             else p = '{PK_R, VC_X, VC_00, 1'b0};
      default: p = '{PK_W, VC_00, VC_00, 1'b0};
    endcase
    return p;
  endfunction

  // Number of passes in a test program.
  function automatic logic [2:0] plan_len(logic [3:0] test);
    logic [2:0] n;
    unique case (test)
      4'd5, 4'd6, 4'd9: n = 3'd4;
      4'd7:             n = 3'd3;
      4'd8:             n = 3'd6;
      default:          n = 3'd2;
    endcase
    return n;
  endfunction

  // Test of each suite position.
  function automatic logic [3:0] suite_test(logic [4:0] pos);
    logic [3:0] t;
    unique case (pos)
      5'd0, 5'd1:          t = 4'd0;
      5'd2, 5'd3:          t = 4'd1;
      5'd4, 5'd5:          t = 4'd2;
      5'd6:                t = 4'd3;
      5'd7:                t = 4'd4;
      5'd8:                t = 4'd5;
      5'd9, 5'd10, 5'd11:  t = 4'd6;
      5'd12:               t = 4'd8;
      5'd13:               t = 4'd9;
      5'd14, 5'd15:        t = 4'd10;
      5'd16, 5'd17:        t = 4'd11;
      5'd18:               t = 4'd7;
      default:             t = 4'd0;
    endcase
    return t;
  endfunction

  // Pattern of each suite position.
  function automatic logic [7:0] suite_pat(logic [4:0] pos);
    logic [7:0] v;
    unique case (pos)
      5'd10, 5'd15, 5'd16: v = 8'h55;
      5'd14, 5'd17:        v = 8'hAA;
      5'd18:               v = 8'hFF;
      default:             v = 8'h00;
    endcase
    return v;
  endfunction

  // Auxiliary flag: checkerboard phase or random-pattern select.
  function automatic logic suite_aux(logic [4:0] pos);
    return (pos == 5'd4) || (pos == 5'd11);
  endfunction

  // Byte for a value code.
  function automatic logic [7:0] value_of(logic [3:0] code, logic [7:0] pat, logic cb_phase,
                                          logic [7:0] offset, logic [2:0] walk);
    logic [7:0] v;
    unique case (code)
      VC_FF:   v = 8'hFF;
      VC_55:   v = 8'h55;
      VC_P:    v = pat;
      VC_N:    v = ~pat;
      VC_CB:   v = ((offset[0] == 1'b0) == cb_phase) ? 8'h55 : 8'hAA;
      VC_W1:   v = 8'd1 << walk;
      VC_W0:   v = ~(8'd1 << walk);
      VC_X:    v = offset ^ pat;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== design/memory_march_test_sequencer.sv =====
// Top level of the memory march test sequencer.
// A start request clears the error counters, latches the region and runs one
// test program or the full suite; a completion request that does not end a pass
// is answered by loading the next write or read request into the result register
// at the same edge, so accesses go at one per cycle while the result register
// is free. At the boundary between passes or tests the sequencer holds its input
// off while it opens the next pass, stepping over any skipped pass, the next
// walking bit or the next suite entry on the way; a start with a nonzero region
// opens the first pass the same way. A run that reaches its end steps the same
// way before the nine summary entries leave, also with the input held off; a
// start with a zero region goes straight to the summary. Results sit in a
// one-entry output register that is refilled in the cycle it is taken.
// Configuration writes are always accepted.
module memory_march_test_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [7:0]  read_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [15:0] mem_address,
  output logic [7:0]  write_byte,
  output logic [3:0]  count_index,
  output logic [31:0] count_value,
  output logic        test_passed,
  output logic        last_entry,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Configuration registers.
  logic [15:0] base_address, region_length;
  logic [3:0]  test_select;
  logic [7:0]  test_pattern, read_repeats, random_pattern;
  logic        checker_phase;
  logic [31:0] retention_ticks;

  // Sequencer state.
  logic        running, running_next;
  logic        suite_mode, suite_mode_next;
  logic [4:0]  suite_position, suite_position_next;
  logic [3:0]  current_test, current_test_next;
  logic [2:0]  test_phase, test_phase_next;
  logic [15:0] address_offset, address_offset_next;
  logic [7:0]  repeat_count, repeat_count_next;
  logic [2:0]  walk_bit, walk_bit_next;
  logic        alternate_flag, alternate_flag_next;
  logic        read_pending, read_pending_next;
  logic [7:0]  expected_byte, expected_byte_next;
  logic [31:0] wait_count, wait_count_next;
  logic [15:0] run_base, run_base_next, run_len, run_len_next;
  logic [31:0] total_errors, total_errors_next;
  logic [31:0] bit_errors [8];
  logic [31:0] bit_errors_next [8];
  logic        advancing, advancing_next;
  logic        sum_active, sum_active_next;
  logic [3:0]  sum_idx, sum_idx_next;

  // Result register contents.
  logic        push;
  logic [1:0]  push_kind;
  logic [15:0] push_addr;
  logic [7:0]  push_byte;
  logic [3:0]  push_idx;
  logic [31:0] push_value;
  logic        push_passed, push_last;

  logic           slot_free, in_fire, do_issue, done, mismatch, compare;
  logic [7:0]     diff, reads_limit, cur_pat, iss_val;
  logic           cb_phase, iss_write;
  logic [31:0]    ticks, wait_dec;
  mmts_pkg::pass_t cur_p, adv_p, iss_p;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = !advancing && !sum_active && slot_free;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign cur_p       = mmts_pkg::pass_of(current_test, test_phase);
  assign adv_p       = mmts_pkg::pass_of(current_test, test_phase);
  assign reads_limit = suite_mode ? mmts_pkg::SuiteReads : read_repeats;
  assign ticks       = suite_mode ? mmts_pkg::SuiteTicks : retention_ticks;
  assign diff        = read_data ^ expected_byte;
  assign wait_dec    = (wait_count != 32'd0) ? wait_count - 32'd1 : 32'd0;

  // Sequencer next-state logic.
  always_comb begin
    running_next        = running;
    suite_mode_next     = suite_mode;
    suite_position_next = suite_position;
    current_test_next   = current_test;
    test_phase_next     = test_phase;
    address_offset_next = address_offset;
    repeat_count_next   = repeat_count;
    walk_bit_next       = walk_bit;
    alternate_flag_next = alternate_flag;
    read_pending_next   = read_pending;
    expected_byte_next  = expected_byte;
    wait_count_next     = wait_count;
    run_base_next       = run_base;
    run_len_next        = run_len;
    total_errors_next   = total_errors;
    bit_errors_next     = bit_errors;
    advancing_next      = advancing;
    sum_active_next     = sum_active;
    sum_idx_next        = sum_idx;
    push        = 1'b0;
    push_kind   = mmts_pkg::RK_WRITE;
    push_addr   = '0;
    push_byte   = '0;
    push_idx    = '0;
    push_value  = '0;
    push_passed = 1'b0;
    push_last   = 1'b0;
    do_issue    = 1'b0;
    done        = 1'b0;
    mismatch    = 1'b0;
    compare     = 1'b0;

    if (in_fire) begin
      unique case (operation)
        mmts_pkg::OP_START: begin
          total_errors_next = '0;
          for (int b = 0; b < 8; b++) bit_errors_next[b] = '0;
          run_base_next       = base_address;
          run_len_next        = region_length;
          running_next        = 1'b1;
          suite_mode_next     = test_select >= mmts_pkg::TEST_SUITE;
          suite_position_next = '0;
          read_pending_next   = 1'b0;
          test_phase_next     = '0;
          walk_bit_next       = '0;
          current_test_next   = (test_select >= mmts_pkg::TEST_SUITE) ?
                                mmts_pkg::suite_test(5'd0) : test_select;
          if (region_length == 16'd0) begin
            running_next    = 1'b0;
            sum_active_next = 1'b1;
            sum_idx_next    = '0;
          end else begin
            advancing_next = 1'b1;
          end
        end
        mmts_pkg::OP_COMPLETE: begin
          if (running && cur_p.kind != mmts_pkg::PK_WAIT) begin
            // Compare the returned byte and count mismatching bits.
            if (read_pending) begin
              compare = (cur_p.kind != mmts_pkg::PK_RN) ||
                        ({1'b0, repeat_count} + 9'd1 >= 9'(mmts_pkg::RepeatAccesses));
              if (compare && diff != 8'd0) begin
                mismatch = 1'b1;
                if (total_errors != mmts_pkg::CountMax)
                  total_errors_next = total_errors + 32'd1;
                for (int b = 0; b < 8; b++)
                  if (diff[b] && bit_errors[b] != mmts_pkg::CountMax)
                    bit_errors_next[b] = bit_errors[b] + 32'd1;
              end
              read_pending_next = 1'b0;
            end
            // Decide whether this cell is finished.
            unique case (cur_p.kind)
              mmts_pkg::PK_WN, mmts_pkg::PK_RN: begin
                repeat_count_next = repeat_count + 8'd1;
                done = ({1'b0, repeat_count} + 9'd1) >= 9'(mmts_pkg::RepeatAccesses);
              end
              mmts_pkg::PK_RD: begin
                repeat_count_next = repeat_count + 8'd1;
                done = mismatch || (({1'b0, repeat_count} + 9'd1) >= {1'b0, reads_limit});
              end
              mmts_pkg::PK_RW: begin
                if (!alternate_flag) alternate_flag_next = 1'b1;
                else done = 1'b1;
              end
              default: done = 1'b1;
            endcase
            if (!done) begin
              do_issue = 1'b1;
            end else begin
              alternate_flag_next = 1'b0;
              repeat_count_next   = '0;
              if (!cur_p.down && ({1'b0, address_offset} + 17'd1 < {1'b0, run_len})) begin
                address_offset_next = address_offset + 16'd1;
                do_issue = 1'b1;
              end else if (cur_p.down && address_offset != 16'd0) begin
                address_offset_next = address_offset - 16'd1;
                do_issue = 1'b1;
              end else begin
                test_phase_next = test_phase + 3'd1;
                advancing_next  = 1'b1;
              end
            end
          end
        end
        mmts_pkg::OP_TICK: begin
          if (running && cur_p.kind == mmts_pkg::PK_WAIT) begin
            wait_count_next = wait_dec;
            if (wait_dec == 32'd0) begin
              test_phase_next = test_phase + 3'd1;
              advancing_next  = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end else if (advancing && slot_free) begin
      // One step of moving to the next pass.
      if (test_phase >= mmts_pkg::plan_len(current_test)) begin
        if ((current_test == mmts_pkg::TEST_WALK1 || current_test == mmts_pkg::TEST_WALK0)
            && walk_bit != 3'd7) begin
          walk_bit_next   = walk_bit + 3'd1;
          test_phase_next = '0;
        end else if (suite_mode && (suite_position + 5'd1 < 5'(mmts_pkg::SuiteLen))) begin
          suite_position_next = suite_position + 5'd1;
          current_test_next   = mmts_pkg::suite_test(suite_position + 5'd1);
          test_phase_next     = '0;
          walk_bit_next       = '0;
        end else begin
          advancing_next    = 1'b0;
          sum_active_next   = 1'b1;
          sum_idx_next      = '0;
          running_next      = 1'b0;
          read_pending_next = 1'b0;
        end
      end else begin
        address_offset_next = adv_p.down ? run_len - 16'd1 : 16'd0;
        repeat_count_next   = '0;
        alternate_flag_next = 1'b0;
        read_pending_next   = 1'b0;
        if (adv_p.kind == mmts_pkg::PK_WAIT) begin
          if (ticks == 32'd0) begin
            test_phase_next = test_phase + 3'd1;
          end else begin
            wait_count_next = ticks;
            push            = 1'b1;
            push_kind       = mmts_pkg::RK_WAIT;
            advancing_next  = 1'b0;
          end
        end else if (adv_p.kind == mmts_pkg::PK_RD && reads_limit == 8'd0) begin
          test_phase_next = test_phase + 3'd1;
        end else begin
          do_issue       = 1'b1;
          advancing_next = 1'b0;
        end
      end
    end else if (sum_active && slot_free) begin
      // Summary entries, bit counts first and the total last.
      push        = 1'b1;
      push_kind   = mmts_pkg::RK_SUMMARY;
      push_idx    = sum_idx;
      push_value  = sum_idx[3] ? total_errors : bit_errors[sum_idx[2:0]];
      push_passed = total_errors == 32'd0;
      push_last   = sum_idx[3];
      sum_idx_next = sum_idx + 4'd1;
      if (sum_idx[3]) sum_active_next = 1'b0;
    end

    // Issue the access of the updated position.
    iss_p     = mmts_pkg::pass_of(current_test_next, test_phase_next);
    iss_write = iss_p.kind == mmts_pkg::PK_W || iss_p.kind == mmts_pkg::PK_WN ||
                (iss_p.kind == mmts_pkg::PK_RW && alternate_flag_next);
    if (!suite_mode_next) begin
      cur_pat  = test_pattern;
      cb_phase = checker_phase;
    end else begin
      cur_pat  = (current_test_next == mmts_pkg::TEST_MOVINV &&
                  mmts_pkg::suite_aux(suite_position_next)) ?
                 random_pattern : mmts_pkg::suite_pat(suite_position_next);
      cb_phase = mmts_pkg::suite_aux(suite_position_next);
    end
    iss_val = mmts_pkg::value_of(iss_write ? iss_p.wv : iss_p.rv, cur_pat, cb_phase,
                                 address_offset_next[7:0], walk_bit_next);
    if (do_issue) begin
      push              = 1'b1;
      push_kind         = iss_write ? mmts_pkg::RK_WRITE : mmts_pkg::RK_READ;
      push_addr         = run_base_next + address_offset_next;
      push_byte         = iss_write ? iss_val : 8'd0;
      read_pending_next = !iss_write;
      if (!iss_write) expected_byte_next = iss_val;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address    <= '0;
      region_length   <= '0;
      test_select     <= mmts_pkg::TEST_SUITE;
      test_pattern    <= 8'h55;
      checker_phase   <= 1'b1;
      read_repeats    <= 8'd5;
      retention_ticks <= 32'd5000;
      random_pattern  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mmts_pkg::REG_BASE:      base_address    <= cfg_data[15:0];
        mmts_pkg::REG_LENGTH:    region_length   <= cfg_data[15:0];
        mmts_pkg::REG_SELECT:    test_select     <= cfg_data[3:0];
        mmts_pkg::REG_PATTERN:   test_pattern    <= cfg_data[7:0];
        mmts_pkg::REG_PHASE:     checker_phase   <= cfg_data[0];
        mmts_pkg::REG_REPEATS:   read_repeats    <= cfg_data[7:0];
        mmts_pkg::REG_RETENTION: retention_ticks <= cfg_data;
        mmts_pkg::REG_RANDOM:    random_pattern  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      running        <= 1'b0;
      suite_mode     <= 1'b0;
      suite_position <= '0;
      current_test   <= '0;
      test_phase     <= '0;
      address_offset <= '0;
      repeat_count   <= '0;
      walk_bit       <= '0;
      alternate_flag <= 1'b0;
      read_pending   <= 1'b0;
      expected_byte  <= '0;
      wait_count     <= '0;
      run_base       <= '0;
      run_len        <= '0;
      total_errors   <= '0;
      for (int b = 0; b < 8; b++) bit_errors[b] <= '0;
      advancing      <= 1'b0;
      sum_active     <= 1'b0;
      sum_idx        <= '0;
    end else begin
      running        <= running_next;
      suite_mode     <= suite_mode_next;
      suite_position <= suite_position_next;
      current_test   <= current_test_next;
      test_phase     <= test_phase_next;
      address_offset <= address_offset_next;
      repeat_count   <= repeat_count_next;
      walk_bit       <= walk_bit_next;
      alternate_flag <= alternate_flag_next;
      read_pending   <= read_pending_next;
      expected_byte  <= expected_byte_next;
      wait_count     <= wait_count_next;
      run_base       <= run_base_next;
      run_len        <= run_len_next;
      total_errors   <= total_errors_next;
      bit_errors     <= bit_errors_next;
      advancing      <= advancing_next;
      sum_active     <= sum_active_next;
      sum_idx        <= sum_idx_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      result_kind <= push_kind;
      mem_address <= push_addr;
      write_byte  <= push_byte;
      count_index <= push_idx;
      count_value <= push_value;
      test_passed <= push_passed;
      last_entry  <= push_last;
    end
  end

`ifndef SYNTH
  // The input stays closed while summary entries drain.
  assert property (@(posedge clk) disable iff (rst) sum_active |-> !in_ready)
    else $error("input open during summary");
  // Pass stepping and summary output never overlap.
  assert property (@(posedge clk) disable iff (rst) !(advancing && sum_active))
    else $error("advance and summary both active");
  // The last summary entry carries the total count.
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && last_entry) |->
                   (result_kind == mmts_pkg::RK_SUMMARY && count_index == 4'd8))
    else $error("bad last summary entry");
  // A started run with a nonzero region leaves the idle state.
  assert property (@(posedge clk) disable iff (rst)
                   (in_fire && operation == mmts_pkg::OP_START && region_length != 16'd0)
                   |=> (running && advancing))
    else $error("start did not launch a run");
`endif

endmodule

// ===== tb/tb_memory_march_test_sequencer.sv =====
// Testbench of the memory march test sequencer: directed and random runs checked by a predictor.
`timescale 1ns / 1ps

module tb_memory_march_test_sequencer;

  localparam int unsigned CycleLimit = 600000;
  localparam longint unsigned CountTop = 64'hFFFF_FFFF;

  // Access step kinds of a test program.
  localparam int SK_W    = 0;
  localparam int SK_WN   = 1;
  localparam int SK_R    = 2;
  localparam int SK_RN   = 3;
  localparam int SK_RW   = 4;
  localparam int SK_RD   = 5;
  localparam int SK_WAIT = 6;

  // Byte sources of a step.
  localparam int BY_ZERO = 0;
  localparam int BY_ONES = 1;
  localparam int BY_5    = 2;
  localparam int BY_PAT  = 3;
  localparam int BY_NPAT = 4;
  localparam int BY_CHK  = 5;
  localparam int BY_W1   = 6;
  localparam int BY_W0   = 7;
  localparam int BY_XOR  = 8;

  localparam int SuiteSize = 19;
  localparam int SuiteTicksCnt = 5000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [7:0]  wbyte;
    logic [3:0]  idx;
    logic [31:0] cnt;
    logic        pass;
    logic        last;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = mmts_pkg::OP_TICK;
  logic [7:0]  read_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  result_kind;
  logic [15:0] mem_address;
  logic [7:0]  write_byte;
  logic [3:0]  count_index;
  logic [31:0] count_value;
  logic        test_passed;
  logic        last_entry;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  memory_march_test_sequencer i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation), .read_data(read_data),
    .out_valid(out_valid), .out_ready(out_ready), .result_kind(result_kind),
    .mem_address(mem_address), .write_byte(write_byte), .count_index(count_index),
    .count_value(count_value), .test_passed(test_passed), .last_entry(last_entry),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Suite order: test, pattern and auxiliary flag of each position.
  int st_test [SuiteSize] = '{0, 0, 1, 1, 2, 2, 3, 4, 5, 6, 6, 6, 8, 9, 10, 10, 11, 11, 7};
  int st_pat  [SuiteSize] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 8'h55, 0, 0, 0,
                              8'hAA, 8'h55, 8'h55, 8'hAA, 8'hFF};
  int st_aux  [SuiteSize] = '{0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0};

  // Register mirror.
  int c_base = 0, c_len = 0, c_sel = 12, c_pat = 8'h55, c_phase = 1, c_reps = 5;
  int c_rand = 0;
  longint unsigned c_ret = 5000;

  // Sequencer state mirror.
  bit m_run, m_suite, m_rdp, m_alt;
  int m_pos, m_test, m_phase, m_off, m_rep, m_walk, m_exp, r_base, r_len;
  longint unsigned m_wait, tot_err;
  longint unsigned bit_err [8];

  outcome_t access_q[$];
  int errors = 0;
  int send_gap_pct = 0, recv_stall_pct = 0;
  int hold_left = 0;
  int unsigned cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic report(input string what, input longint unsigned want, input longint unsigned got);
    errors++;
    $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
  endtask

  // Receiver: random stalls, long hold-offs, and field checks of each result.
  always @(posedge clk) begin
    outcome_t w;
    if (out_valid && out_ready) begin
      if (access_q.size() == 0) begin
        report("unexpected result kind", 0, result_kind);
      end else begin
        w = access_q.pop_front();
        if (result_kind !== w.kind) report("result_kind", w.kind, result_kind);
        if (mem_address !== w.addr) report("mem_address", w.addr, mem_address);
        if (write_byte !== w.wbyte) report("write_byte", w.wbyte, write_byte);
        if (count_index !== w.idx) report("count_index", w.idx, count_index);
        if (count_value !== w.cnt) report("count_value", w.cnt, count_value);
        if (test_passed !== w.pass) report("test_passed", w.pass, test_passed);
        if (last_entry !== w.last) report("last_entry", w.last, last_entry);
      end
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Pass table of each test program.
  function automatic void plan_step(input int t, input int ph, output int k, output int rv,
                                    output int wv, output bit dn);
    k = SK_W; rv = BY_ZERO; wv = BY_ZERO; dn = 1'b0;
    case (t)
      0: if (ph == 0) begin k = SK_WN; wv = BY_5; end else begin k = SK_R; rv = BY_5; end
      1: if (ph == 0) wv = BY_5; else begin k = SK_RN; rv = BY_5; end
      2: if (ph == 0) wv = BY_CHK; else begin k = SK_R; rv = BY_CHK; end
      3: if (ph == 0) wv = BY_W1; else begin k = SK_R; rv = BY_W1; end
      4: if (ph == 0) wv = BY_W0; else begin k = SK_R; rv = BY_W0; end
      5, 9: case (ph)
        0: ;
        1: begin k = SK_RW; wv = BY_ONES; end
        2: begin k = SK_RW; rv = BY_ONES; dn = 1'b1; end
        default: begin k = SK_R; dn = 1'b1; end
      endcase
      6: case (ph)
        0: wv = BY_PAT;
        1: begin k = SK_RW; rv = BY_PAT; wv = BY_NPAT; end
        2: begin k = SK_RW; rv = BY_NPAT; wv = BY_PAT; end
        default: begin k = SK_R; rv = BY_PAT; end
      endcase
      7: case (ph)
        0: wv = BY_PAT;
        1: k = SK_WAIT;
        default: begin k = SK_R; rv = BY_PAT; end
      endcase
      8: case (ph)
        0: ;
        1: begin k = SK_RW; wv = BY_ONES; end
        2: begin k = SK_RW; rv = BY_ONES; dn = 1'b1; end
        3: begin k = SK_RW; wv = BY_ONES; dn = 1'b1; end
        4: begin k = SK_RW; rv = BY_ONES; end
        default: k = SK_R;
      endcase
      10: if (ph == 0) wv = BY_PAT; else begin k = SK_RD; rv = BY_PAT; end
      11: if (ph == 0) wv = BY_XOR; else begin k = SK_R; rv = BY_XOR; end
      default: ;
    endcase
  endfunction

  function automatic int passes_in(input int t);
    case (t)
      5, 6, 9: return 4;
      7: return 3;
      8: return 6;
      default: return 2;
    endcase
  endfunction

  function automatic int step_kind();
    int k, rv, wv;
    bit dn;
    plan_step(m_test, m_phase, k, rv, wv, dn);
    return k;
  endfunction

  function automatic int byte_of(input int src);
    int p, ph;
    if (!m_suite) p = c_pat;
    else if (st_test[m_pos] == 6 && st_aux[m_pos] != 0) p = c_rand;
    else p = st_pat[m_pos];
    ph = m_suite ? st_aux[m_pos] : c_phase;
    case (src)
      BY_ONES: return 8'hFF;
      BY_5:    return 8'h55;
      BY_PAT:  return p;
      BY_NPAT: return (~p) & 8'hFF;
      BY_CHK:  return (((m_off & 1) == 0) == (ph == 1)) ? 8'h55 : 8'hAA;
      BY_W1:   return (1 << m_walk) & 8'hFF;
      BY_W0:   return (~(1 << m_walk)) & 8'hFF;
      BY_XOR:  return (m_off & 8'hFF) ^ p;
      default: return 0;
    endcase
  endfunction

  function automatic void push(input int kind, input int addr, input int wb, input int idx,
                               input longint unsigned cnt, input bit pass, input bit last);
    outcome_t o;
    o.kind = 2'(kind); o.addr = 16'(addr); o.wbyte = 8'(wb); o.idx = 4'(idx);
    o.cnt = 32'(cnt); o.pass = pass; o.last = last;
    access_q.push_back(o);
  endfunction

  function automatic void post_summary();
    bit ok;
    ok = (tot_err == 0);
    m_run = 1'b0;
    m_rdp = 1'b0;
    for (int b = 0; b < 8; b++) push(mmts_pkg::RK_SUMMARY, 0, 0, b, bit_err[b], ok, 1'b0);
    push(mmts_pkg::RK_SUMMARY, 0, 0, 8, tot_err, ok, 1'b1);
  endfunction

  function automatic void next_access();
    int k, rv, wv, addr;
    bit dn;
    plan_step(m_test, m_phase, k, rv, wv, dn);
    addr = (r_base + m_off) & 16'hFFFF;
    if (k == SK_W || k == SK_WN || (k == SK_RW && m_alt)) begin
      m_rdp = 1'b0;
      push(mmts_pkg::RK_WRITE, addr, byte_of(wv), 0, 0, 1'b0, 1'b0);
    end else begin
      m_exp = byte_of(rv);
      m_rdp = 1'b1;
      push(mmts_pkg::RK_READ, addr, 0, 0, 0, 1'b0, 1'b0);
    end
  endfunction

  function automatic void load_program();
    m_test = m_suite ? st_test[m_pos] : c_sel;
    m_phase = 0;
    m_walk = 0;
  endfunction

  // Walks the plan forward to the next pass that issues something, or to the summary.
  function automatic void open_pass();
    int k, rv, wv;
    bit dn;
    while (1) begin
      if (m_phase >= passes_in(m_test)) begin
        if ((m_test == 3 || m_test == 4) && m_walk < 7) begin
          m_walk++;
          m_phase = 0;
          continue;
        end
        if (m_suite && m_pos + 1 < SuiteSize) begin
          m_pos++;
          load_program();
          continue;
        end
        post_summary();
        return;
      end
      plan_step(m_test, m_phase, k, rv, wv, dn);
      m_off = dn ? ((r_len - 1) & 16'hFFFF) : 0;
      m_rep = 0;
      m_alt = 1'b0;
      m_rdp = 1'b0;
      if (k == SK_WAIT) begin
        m_wait = m_suite ? SuiteTicksCnt : c_ret;
        if (m_wait == 0) begin
          m_phase++;
          continue;
        end
        push(mmts_pkg::RK_WAIT, 0, 0, 0, 0, 1'b0, 1'b0);
        return;
      end
      if (k == SK_RD && (m_suite ? 5 : c_reps) == 0) begin
        m_phase++;
        continue;
      end
      next_access();
      return;
    end
  endfunction

  function automatic void access_done(input int data);
    int k, rv, wv, diff;
    bit dn, done, bad;
    plan_step(m_test, m_phase, k, rv, wv, dn);
    done = 1'b0;
    bad = 1'b0;
    if (m_rdp) begin
      diff = (data ^ m_exp) & 8'hFF;
      if ((k != SK_RN || m_rep + 1 >= mmts_pkg::RepeatAccesses) && diff != 0) begin
        bad = 1'b1;
        if (tot_err < CountTop) tot_err++;
        for (int b = 0; b < 8; b++)
          if (diff[b] && bit_err[b] < CountTop) bit_err[b]++;
      end
      m_rdp = 1'b0;
    end
    case (k)
      SK_WN, SK_RN: begin
        m_rep++;
        done = (m_rep >= mmts_pkg::RepeatAccesses);
      end
      SK_RD: begin
        m_rep++;
        done = bad || m_rep >= (m_suite ? 5 : c_reps);
      end
      SK_RW: if (!m_alt) m_alt = 1'b1; else done = 1'b1;
      default: done = 1'b1;
    endcase
    if (!done) begin
      next_access();
      return;
    end
    m_alt = 1'b0;
    m_rep = 0;
    if (!dn) begin
      if (m_off + 1 < r_len) begin
        m_off++;
        next_access();
        return;
      end
    end else if (m_off > 0) begin
      m_off--;
      next_access();
      return;
    end
    m_phase++;
    open_pass();
  endfunction

  // Expected results of one accepted request.
  function automatic void predict(input logic [1:0] op, input logic [7:0] data);
    if (op == mmts_pkg::OP_START) begin
      tot_err = 0;
      for (int b = 0; b < 8; b++) bit_err[b] = 0;
      r_base = c_base;
      r_len = c_len;
      m_run = 1'b1;
      m_suite = (c_sel >= 12);
      m_pos = 0;
      m_rdp = 1'b0;
      if (r_len == 0) begin
        post_summary();
        return;
      end
      load_program();
      open_pass();
      return;
    end
    if (!m_run) return;
    if (op == mmts_pkg::OP_COMPLETE) begin
      if (step_kind() != SK_WAIT) access_done(data);
    end else if (op == mmts_pkg::OP_TICK && step_kind() == SK_WAIT) begin
      if (m_wait > 0) m_wait--;
      if (m_wait == 0) begin
        m_phase++;
        open_pass();
      end
    end
  endfunction

  // Sends one request; valid stays high into the next call unless a gap is taken.
  task automatic send(input logic [1:0] op, input logic [7:0] data);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    read_data <= data;
    do @(posedge clk); while (!in_ready);
    predict(op, data);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      mmts_pkg::REG_BASE:      c_base = value[15:0];
      mmts_pkg::REG_LENGTH:    c_len = value[15:0];
      mmts_pkg::REG_SELECT:    c_sel = value[3:0];
      mmts_pkg::REG_PATTERN:   c_pat = value[7:0];
      mmts_pkg::REG_PHASE:     c_phase = value[0];
      mmts_pkg::REG_REPEATS:   c_reps = value[7:0];
      mmts_pkg::REG_RETENTION: c_ret = value;
      default:                 c_rand = value[7:0];
    endcase
  endtask

  // Lets the block drain before registers change.
  task automatic settle();
    in_valid <= 1'b0;
    while (access_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Answers the run's requests; bad_pct of the reads come back corrupted.
  task automatic answer_run(input int max_items, input int bad_pct);
    int n;
    logic [7:0] d;
    n = 0;
    while (m_run && n < max_items) begin
      if (step_kind() == SK_WAIT) begin
        send(mmts_pkg::OP_TICK, 8'($urandom));
      end else begin
        d = (m_rdp && $urandom_range(99) >= bad_pct) ? 8'(m_exp) : 8'($urandom);
        send(mmts_pkg::OP_COMPLETE, d);
      end
      n++;
    end
  endtask

  task automatic setup(input int base, input int len, input int sel);
    settle();
    write_reg(mmts_pkg::REG_BASE, base);
    write_reg(mmts_pkg::REG_LENGTH, len);
    write_reg(mmts_pkg::REG_SELECT, sel);
  endtask

  // Directed: extremes, ignored requests, restart, every program once.
  task automatic test_directed();
    setup(16'hFFFF, 0, 0);
    write_reg(mmts_pkg::REG_PATTERN, 8'hFF);
    write_reg(mmts_pkg::REG_PHASE, 0);
    write_reg(mmts_pkg::REG_REPEATS, 0);
    write_reg(mmts_pkg::REG_RETENTION, 32'hFFFF_FFFF);
    write_reg(mmts_pkg::REG_RANDOM, 8'hFF);
    send(mmts_pkg::OP_COMPLETE, 8'hFF);
    send(mmts_pkg::OP_TICK, 8'h00);
    send(2'd3, 8'hA5);
    send(mmts_pkg::OP_START, 8'h00);
    setup(16'hFFFF, 16'hFFFF, 5);
    send(mmts_pkg::OP_START, 8'h00);
    answer_run(4, 0);
    send(mmts_pkg::OP_TICK, 8'h00);
    send(mmts_pkg::OP_START, 8'h00);
    answer_run(3, 50);
    setup(16'hFFFE, 3, 10);
    send(mmts_pkg::OP_START, 8'h00);
    answer_run(1000, 30);
    settle();
    write_reg(mmts_pkg::REG_RETENTION, 0);
    for (int t = 0; t < 12; t++) begin
      setup(16'hFFFF, 1, t);
      write_reg(mmts_pkg::REG_PATTERN, (t & 1) ? 8'h00 : 8'hFF);
      write_reg(mmts_pkg::REG_PHASE, t & 1);
      write_reg(mmts_pkg::REG_REPEATS, (t == 10) ? 255 : 2);
      if (t == 7) write_reg(mmts_pkg::REG_RETENTION, 2);
      send(mmts_pkg::OP_START, 8'h00);
      answer_run(4000, 20);
    end
  endtask

  // The suite runs through its tests into the retention wait; before that, selector 15,
  // which also selects the suite, is started and left unfinished.
  task automatic test_full_suite();
    setup(16'h1234, 1, 15);
    send(mmts_pkg::OP_START, 8'h00);
    answer_run(10, 10);
    settle();
    write_reg(mmts_pkg::REG_SELECT, mmts_pkg::TEST_SUITE);
    write_reg(mmts_pkg::REG_RANDOM, 8'h3C);
    send(mmts_pkg::OP_START, 8'h00);
    answer_run(120, 10);
  endtask

  // Random runs with random registers, mostly well-formed with some noise.
  task automatic test_random(input int budget);
    int used, r;
    used = 0;
    while (used < budget) begin
      setup($urandom_range(16'hFFFF), ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4),
            $urandom_range(11));
      write_reg(mmts_pkg::REG_PATTERN, $urandom_range(255));
      write_reg(mmts_pkg::REG_PHASE, $urandom_range(1));
      write_reg(mmts_pkg::REG_REPEATS, $urandom_range(6));
      write_reg(mmts_pkg::REG_RETENTION, $urandom_range(4));
      send(mmts_pkg::OP_START, 8'($urandom));
      used++;
      while (m_run && used < budget + 200) begin
        r = $urandom_range(99);
        if (r < 3) send(mmts_pkg::OP_START, 8'($urandom));
        else if (r < 8) send(2'($urandom_range(3)), 8'($urandom));
        else answer_run(1, 15);
        used++;
      end
    end
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    setup(16'h00F0, 2, 8);
    send(mmts_pkg::OP_START, 8'h00);
    hold_left = 300;
    answer_run(5000, 10);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_gap_pct = 35;
    recv_stall_pct = 45;
    test_directed();
    test_random(10);
    send_gap_pct = 45;
    recv_stall_pct = 35;
    test_backpressure();
    test_random(10);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    test_full_suite();
    test_random(10);
    in_valid <= 1'b0;
    while (access_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && access_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/mmts_pkg.sv
design/memory_march_test_sequencer.sv
tb/tb_memory_march_test_sequencer.sv
